### rtl/core/kpt_pkg.sv
// Shared constants and types for the keyed pair table.
package kpt_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned SQ_W      = 6;
  localparam int unsigned PL_W      = 32;
  localparam int unsigned CNT_OUT_W = 5;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

endpackage

### rtl/core/kpt_ifs.sv
// Valid/ready channel interfaces for the keyed pair table request and result beats.
interface kpt_in_if;
  import kpt_pkg::*;

  logic            valid;
  logic            ready;
  op_t             opcode;
  logic [SQ_W-1:0] from_square;
  logic [SQ_W-1:0] to_square;
  logic [PL_W-1:0] payload;

  modport source (output valid, output opcode, output from_square, output to_square,
                  output payload, input ready);
  modport sink   (input valid, input opcode, input from_square, input to_square,
                  input payload, output ready);
endinterface

interface kpt_out_if;
  import kpt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic [CNT_OUT_W-1:0] entry_count;

  modport source (output valid, output ok, output entry_count, input ready);
  modport sink   (input valid, input ok, input entry_count, output ready);
endinterface

### rtl/core/keyed_pair_table_core.sv
// Packed key/value table keyed by a pair of squares, searched by one shared comparator.
// One request beat is taken at a time; in_bus.ready is high only while the sequencer is
// idle. The table lives in a single-port-read memory with a registered read, and one
// comparator walks the valid entries one per cycle; an add, remove or query ends its
// scan early when the key is found, a rejected add or a clear skips the scan, and a
// remove that hits then moves each entry behind the hit down by one place, through a
// read state (SHIFT) and a write state (SHWR).
// The result beat sits in an output register; a new request is taken while it waits.
// No clearing pass is needed after reset: only entries below the count are ever read.
module keyed_pair_table_core #(
  parameter int unsigned DEPTH = kpt_pkg::DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  kpt_in_if.sink    in_bus,
  kpt_out_if.source out_bus
);
  import kpt_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef struct packed {
    logic [SQ_W-1:0] from_sq;
    logic [SQ_W-1:0] to_sq;
    logic [PL_W-1:0] payload;
  } entry_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_SHIFT = 5'b00100,
    ST_SHWR  = 5'b01000,
    ST_RESP  = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  op_t                  op_r, op_nxt;
  logic [SQ_W-1:0]      from_r, from_nxt;
  logic [SQ_W-1:0]      to_r, to_nxt;
  logic [PL_W-1:0]      pl_r, pl_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic                 cmp_vld_r, cmp_vld_nxt;
  logic                 ok_r, ok_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_ok_r, out_ok_nxt;
  logic [CNT_OUT_W-1:0] out_count_r, out_count_nxt;

  entry_t               mem [DEPTH];
  entry_t               rd_data_r;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  entry_t               wr_data;

  logic                 hit;
  logic                 more;
  logic [CNT_W:0]       idx_inc;
  logic                 shift_more;

  assign hit        = cmp_vld_r && (rd_data_r.from_sq == from_r) && (rd_data_r.to_sq == to_r);
  assign more       = idx_r < count_r;
  assign idx_inc    = (CNT_W+1)'(idx_r) + (CNT_W+1)'(1);
  assign shift_more = idx_inc < (CNT_W+1)'(count_r);

  assign in_bus.ready        = (state_r == ST_IDLE);
  assign out_bus.valid       = out_valid_r;
  assign out_bus.ok          = out_ok_r;
  assign out_bus.entry_count = out_count_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    from_nxt      = from_r;
    to_nxt        = to_r;
    pl_nxt        = pl_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_vld_nxt   = cmp_vld_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_count_nxt = out_count_r;
    rd_en         = 1'b0;
    rd_addr       = idx_r[IDX_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = idx_r[IDX_W-1:0];
    wr_data       = rd_data_r;

    if (out_valid_r && out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_bus.valid) begin
          op_nxt      = in_bus.opcode;
          from_nxt    = in_bus.from_square;
          to_nxt      = in_bus.to_square;
          pl_nxt      = in_bus.payload;
          idx_nxt     = '0;
          cmp_vld_nxt = 1'b0;
          unique case (in_bus.opcode)
            OP_CLEAR: begin
              count_nxt = '0;
              ok_nxt    = 1'b1;
              state_nxt = ST_RESP;
            end
            OP_ADD: begin
              if (count_r >= CNT_W'(DEPTH) || in_bus.from_square == in_bus.to_square) begin
                ok_nxt    = 1'b0;
                state_nxt = ST_RESP;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            default: state_nxt = ST_SCAN;
          endcase
        end
      end

      ST_SCAN: begin
        if (hit) begin
          cmp_vld_nxt = 1'b0;
          unique case (op_r)
            OP_ADD: begin
              wr_en     = 1'b1;
              wr_addr   = cmp_idx_r[IDX_W-1:0];
              wr_data   = '{from_sq: from_r, to_sq: to_r, payload: pl_r};
              ok_nxt    = 1'b1;
              state_nxt = ST_RESP;
            end
            OP_REMOVE: begin
              idx_nxt   = cmp_idx_r;
              state_nxt = ST_SHIFT;
            end
            default: begin
              ok_nxt    = 1'b1;
              state_nxt = ST_RESP;
            end
          endcase
        end else if (more) begin
          rd_en       = 1'b1;
          rd_addr     = idx_r[IDX_W-1:0];
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = idx_r;
          idx_nxt     = idx_inc[CNT_W-1:0];
        end else begin
          cmp_vld_nxt = 1'b0;
          if (op_r == OP_ADD) begin
            wr_en     = 1'b1;
            wr_addr   = count_r[IDX_W-1:0];
            wr_data   = '{from_sq: from_r, to_sq: to_r, payload: pl_r};
            count_nxt = count_r + CNT_W'(1);
            ok_nxt    = 1'b1;
          end else begin
            ok_nxt    = 1'b0;
          end
          state_nxt = ST_RESP;
        end
      end

      ST_SHIFT: begin
        if (shift_more) begin
          rd_en     = 1'b1;
          rd_addr   = idx_inc[IDX_W-1:0];
          state_nxt = ST_SHWR;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          ok_nxt    = 1'b1;
          state_nxt = ST_RESP;
        end
      end

      ST_SHWR: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r[IDX_W-1:0];
        wr_data   = rd_data_r;
        idx_nxt   = idx_inc[CNT_W-1:0];
        state_nxt = ST_SHIFT;
      end

      ST_RESP: begin
        if (!out_valid_r || out_bus.ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_count_nxt = CNT_OUT_W'(count_r);
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    from_r      <= from_nxt;
    to_r        <= to_nxt;
    pl_r        <= pl_nxt;
    idx_r       <= idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    ok_r        <= ok_nxt;
    out_ok_r    <= out_ok_nxt;
    out_count_r <= out_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/kpt_checker.sv
// Port-level assertions for the keyed pair table, bound to keyed_pair_table_core.
module kpt_checker #(
  parameter int unsigned DEPTH = kpt_pkg::DEPTH_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_ok,
  input logic [kpt_pkg::CNT_OUT_W-1:0] out_entry_count
);
  import kpt_pkg::*;

  logic [CNT_OUT_W-1:0] prev_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_cnt_r <= '0;
    end else if (out_valid && out_ready) begin
      prev_cnt_r <= out_entry_count;
    end
  end

  // one request in flight: ready drops right after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while previous one still in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((DEPTH >= 32) || (out_entry_count <= DEPTH)))
    else $error("entry count above table depth");

  // count moves by at most one per operation, except clear
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |->
      (out_entry_count == '0) || (out_entry_count == prev_cnt_r) ||
      (out_entry_count == prev_cnt_r + 5'd1) || (out_entry_count == prev_cnt_r - 5'd1))
    else $error("entry count jumped by more than one");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_ok) && $stable(out_entry_count)))
    else $error("stalled result beat changed");

endmodule

bind keyed_pair_table_core kpt_checker #(.DEPTH(DEPTH)) u_kpt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_bus.valid),
  .in_ready        (in_bus.ready),
  .out_valid       (out_bus.valid),
  .out_ready       (out_bus.ready),
  .out_ok          (out_bus.ok),
  .out_entry_count (out_bus.entry_count)
);
